// ===== sv/crc16fe_pkg.sv =====
// ----------------------------------------------------------------------------
// CRC-16 frame encoder package
// Shared types, codes and the CRC-16/XMODEM byte update for the frame encoder.
// ----------------------------------------------------------------------------
package crc16fe_pkg;

  localparam int unsigned MaxFrameBytes = 1024;
  localparam int unsigned LenLimit      = MaxFrameBytes - 8;
  localparam int unsigned HeaderBytes   = 6;

  localparam logic [7:0]  SofByte      = 8'hA3;
  localparam logic [7:0]  SourceIdRst  = 8'h27;
  localparam logic [15:0] CrcPoly      = 16'h1021;
  localparam logic [15:0] CrcInit      = 16'h0000;

  typedef enum logic {
    OpStart   = 1'b0,
    OpPayload = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    StOk          = 2'd0,
    StLenTooLarge = 2'd1,
    StNoFrame     = 2'd2,
    StStartOpen   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    KindError,
    KindHeader,
    KindData
  } kind_e;

  typedef struct packed {
    op_e        operation;
    logic [7:0] dest_id;
    logic [7:0] command;
    logic [9:0] payload_length;
    logic [7:0] payload_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_frame;
    logic       end_of_run;
    status_e    status;
  } out_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== sv/crc16_frame_encoder_top.sv =====
// ----------------------------------------------------------------------------
// CRC-16 frame encoder
// Turns start and payload transactions into a byte stream framed with a
// six-byte header and a CRC-16/XMODEM trailer.
// ----------------------------------------------------------------------------
// Usage:
// The input channel takes one transaction per item: a start item opens a frame
// and a payload item carries one data byte. The output channel returns one
// byte of the frame per transaction, with end_of_frame on the CRC low byte,
// end_of_run on the last byte caused by an input item, and a status code on
// rejected items. An accepted item is held in an item register, and its
// results are produced one per cycle into an output register while the
// receiver does not stall, so the first result passes the item register and
// then the output register before it is shown. A payload item or a rejected
// item gives one result, a payload item that ends a frame three results, a
// start item six results and a start item with an empty payload eight.
// The next item is accepted in the cycle the current item's last result is
// produced. When the receiver stalls, the output register holds its byte and
// the input stalls as soon as the item register is occupied. Reset empties
// both registers, closes any open frame, clears the CRC and sets source_id
// to 0x27. The source id is written through cfg_we_i and cfg_wdata_i.
// ----------------------------------------------------------------------------
module crc16_frame_encoder_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  crc16fe_pkg::in_t   in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output crc16fe_pkg::out_t  out_data_o
);

  localparam logic [16:0] LenLimitW = 17'(crc16fe_pkg::LenLimit);
  localparam logic [15:0] HdrLenW   = 16'(crc16fe_pkg::HeaderBytes);

  logic [7:0]          source_id_q;
  logic [15:0]         crc_q, crc_d;
  logic [9:0]          rem_q, rem_d;
  logic                open_q, open_d;
  logic                busy_q;
  logic [2:0]          step_q;
  crc16fe_pkg::in_t    item_q;
  logic                out_valid_q;
  crc16fe_pkg::out_t   out_q, out_d;

  logic                out_free;
  logic                emit;
  logic                last;
  logic                in_accept;
  crc16fe_pkg::kind_e  kind;
  crc16fe_pkg::status_e err_status;
  logic [15:0]         total_len;
  logic [7:0]          hdr_byte;
  logic [9:0]          rem_dec;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign emit       = busy_q && out_free;
  assign in_stall_o = busy_q && !(emit && last);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign total_len  = {6'b0, item_q.payload_length} + HdrLenW;
  assign rem_dec    = (rem_q != '0) ? rem_q - 10'd1 : rem_q;

  always_comb begin
    kind       = crc16fe_pkg::KindError;
    err_status = crc16fe_pkg::StOk;
    if (item_q.operation == crc16fe_pkg::OpStart) begin
      if (open_q) begin
        err_status = crc16fe_pkg::StStartOpen;
      end else if ({7'b0, item_q.payload_length} > LenLimitW) begin
        err_status = crc16fe_pkg::StLenTooLarge;
      end else begin
        kind = crc16fe_pkg::KindHeader;
      end
    end else begin
      if (open_q) begin
        kind = crc16fe_pkg::KindData;
      end else begin
        err_status = crc16fe_pkg::StNoFrame;
      end
    end
  end

  always_comb begin
    case (step_q)
      3'd0:    hdr_byte = crc16fe_pkg::SofByte;
      3'd1:    hdr_byte = source_id_q;
      3'd2:    hdr_byte = item_q.dest_id;
      3'd3:    hdr_byte = item_q.command;
      3'd4:    hdr_byte = total_len[15:8];
      3'd5:    hdr_byte = total_len[7:0];
      default: hdr_byte = '0;
    endcase
  end

  always_comb begin
    out_d  = '0;
    last   = 1'b0;
    crc_d  = crc_q;
    rem_d  = rem_q;
    open_d = open_q;
    if (emit) begin
      case (kind)
        crc16fe_pkg::KindHeader: begin
          if (step_q < 3'd6) begin
            out_d.out_byte = hdr_byte;
            crc_d = crc16fe_pkg::crc_byte((step_q == 3'd0) ? crc16fe_pkg::CrcInit : crc_q,
                                          hdr_byte);
            if (step_q == 3'd5 && item_q.payload_length != '0) begin
              open_d           = 1'b1;
              rem_d            = item_q.payload_length;
              out_d.end_of_run = 1'b1;
              last             = 1'b1;
            end
          end else if (step_q == 3'd6) begin
            out_d.out_byte = crc_q[15:8];
          end else begin
            out_d.out_byte     = crc_q[7:0];
            out_d.end_of_frame = 1'b1;
            out_d.end_of_run   = 1'b1;
            last               = 1'b1;
            crc_d              = crc16fe_pkg::CrcInit;
            rem_d              = '0;
            open_d             = 1'b0;
          end
        end
        crc16fe_pkg::KindData: begin
          if (step_q == 3'd0) begin
            out_d.out_byte = item_q.payload_byte;
            crc_d          = crc16fe_pkg::crc_byte(crc_q, item_q.payload_byte);
            rem_d          = rem_dec;
            if (rem_dec != '0) begin
              out_d.end_of_run = 1'b1;
              last             = 1'b1;
            end
          end else if (step_q == 3'd1) begin
            out_d.out_byte = crc_q[15:8];
          end else begin
            out_d.out_byte     = crc_q[7:0];
            out_d.end_of_frame = 1'b1;
            out_d.end_of_run   = 1'b1;
            last               = 1'b1;
            crc_d              = crc16fe_pkg::CrcInit;
            rem_d              = '0;
            open_d             = 1'b0;
          end
        end
        default: begin
          out_d.status     = err_status;
          out_d.end_of_run = 1'b1;
          last             = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_id_q <= crc16fe_pkg::SourceIdRst;
      crc_q       <= crc16fe_pkg::CrcInit;
      rem_q       <= '0;
      open_q      <= 1'b0;
      busy_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        source_id_q <= cfg_wdata_i;
      end
      crc_q  <= crc_d;
      rem_q  <= rem_d;
      open_q <= open_d;
      if (in_accept) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (emit && last) begin
        busy_q <= 1'b0;
      end else if (emit) begin
        step_q <= step_q + 3'd1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_data_i;
    end
    if (emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_closed_frame_no_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !open_q |-> rem_q == '0)
    else $error("bytes remain counted while no frame is open");

  a_eof_clears_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && out_d.end_of_frame) |=> (!open_q && crc_q == crc16fe_pkg::CrcInit))
    else $error("frame state not cleared after the trailer");

  a_accept_starts_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (busy_q && step_q == '0))
    else $error("accepted transaction did not start at its first result");

  a_error_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && out_d.status != crc16fe_pkg::StOk) |-> (last && out_d.end_of_run))
    else $error("rejected item produced more than one result");

endmodule

// ===== tb/crc16_frame_encoder_checker.sv =====
// ----------------------------------------------------------------------------
// CRC-16 frame encoder checker
// Watches the configuration port and both channels of the frame encoder. For
// every accepted input transaction it computes the frame bytes the encoder must
// send, and it compares every accepted output transaction with the oldest of
// them. It reports the number of failures and of bytes still outstanding.
// ----------------------------------------------------------------------------
module crc16_frame_encoder_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  crc16fe_pkg::in_t   in_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  crc16fe_pkg::out_t  out_data_i,
  output int unsigned        fail_count_o,
  output int unsigned        pending_o
);

  import crc16fe_pkg::*;

  logic [7:0]  src_id_q;
  logic [15:0] crc_acc;
  logic [9:0]  left_cnt;
  logic        in_frame;
  out_t        frame_q[$];
  int unsigned errs;

  function automatic logic [15:0] crc16_next(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = c;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r  = {r[14:0], 1'b0} ^ (fb ? CrcPoly : 16'h0000);
    end
    return r;
  endfunction

  function automatic void note(input logic [7:0] b, input logic eof, input logic eor,
                               input status_e st);
    out_t r;
    r.out_byte     = b;
    r.end_of_frame = eof;
    r.end_of_run   = eor;
    r.status       = st;
    frame_q.push_back(r);
  endfunction

  function automatic void note_framed(input logic [7:0] b, input logic eor);
    crc_acc = crc16_next(crc_acc, b);
    note(b, 1'b0, eor, StOk);
  endfunction

  function automatic void note_trailer();
    note(crc_acc[15:8], 1'b0, 1'b0, StOk);
    note(crc_acc[7:0], 1'b1, 1'b1, StOk);
    in_frame = 1'b0;
    left_cnt = '0;
    crc_acc  = CrcInit;
  endfunction

  function automatic void encode_item(input in_t it);
    logic [15:0] total;
    logic        last;
    if (it.operation == OpStart) begin
      if (in_frame) begin
        note(8'h00, 1'b0, 1'b1, StStartOpen);
      end else if (it.payload_length > LenLimit) begin
        note(8'h00, 1'b0, 1'b1, StLenTooLarge);
      end else begin
        total   = 16'(it.payload_length) + 16'(HeaderBytes);
        crc_acc = CrcInit;
        note_framed(SofByte, 1'b0);
        note_framed(src_id_q, 1'b0);
        note_framed(it.dest_id, 1'b0);
        note_framed(it.command, 1'b0);
        note_framed(total[15:8], 1'b0);
        note_framed(total[7:0], it.payload_length != 0);
        if (it.payload_length == 0) begin
          note_trailer();
        end else begin
          in_frame = 1'b1;
          left_cnt = it.payload_length;
        end
      end
    end else begin
      if (!in_frame) begin
        note(8'h00, 1'b0, 1'b1, StNoFrame);
      end else begin
        last = (left_cnt <= 10'd1);
        note_framed(it.payload_byte, !last);
        if (left_cnt != 0) begin
          left_cnt = left_cnt - 10'd1;
        end
        if (last) begin
          note_trailer();
        end
      end
    end
  endfunction

  function automatic void check_byte(input out_t got);
    out_t want;
    if (frame_q.size() == 0) begin
      $error("output transaction with nothing expected: out_byte %0h status %0d",
             got.out_byte, got.status);
      errs++;
    end else begin
      want = frame_q.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected %0h, actual %0h", want.out_byte, got.out_byte);
        errs++;
      end
      if (got.end_of_frame !== want.end_of_frame) begin
        $error("end_of_frame: expected %0b, actual %0b", want.end_of_frame, got.end_of_frame);
        errs++;
      end
      if (got.end_of_run !== want.end_of_run) begin
        $error("end_of_run: expected %0b, actual %0b", want.end_of_run, got.end_of_run);
        errs++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errs++;
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_id_q = SourceIdRst;
      crc_acc  = CrcInit;
      left_cnt = '0;
      in_frame = 1'b0;
      frame_q.delete();
      errs     = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        check_byte(out_data_i);
      end
      if (in_valid_i && !in_stall_i) begin
        encode_item(in_data_i);
      end
      if (cfg_we_i) begin
        src_id_q = cfg_wdata_i;
      end
    end
    fail_count_o <= errs;
    pending_o    <= frame_q.size();
  end

endmodule

// ===== tb/crc16_frame_encoder_top_tb.sv =====
// ----------------------------------------------------------------------------
// CRC-16 frame encoder testbench
// Drives start and payload transactions into the frame encoder: a directed
// set of frames and error cases, then random frames mixed with malformed
// items under several source ids, random stalls on both sides and one long
// receiver hold-off. A checker beside the encoder predicts and compares every
// output byte; this module gives the verdict.
// ----------------------------------------------------------------------------
module crc16_frame_encoder_top_tb;

  import crc16fe_pkg::*;

  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned HoldCycles = 90;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [7:0]  cfg_wdata = 8'h00;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_t         in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned items_sent    = 0;
  int unsigned in_gap_pct    = 6;
  int unsigned out_gap_pct   = 6;
  int unsigned hold_requests = 0;
  int unsigned holds_done    = 0;
  int unsigned hold_left     = 0;
  int unsigned quiet_cycles  = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  crc16_frame_encoder_top uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  crc16_frame_encoder_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk) begin
    if (holds_done != hold_requests) begin
      holds_done <= hold_requests;
      hold_left  <= HoldCycles;
      out_stall  <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < out_gap_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("FAIL crc16_frame_encoder_top");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic in_t make_item(input op_e op, input logic [7:0] dest,
                                    input logic [7:0] cmd, input logic [9:0] len,
                                    input logic [7:0] pbyte);
    in_t it;
    it.operation      = op;
    it.dest_id        = dest;
    it.command        = cmd;
    it.payload_length = len;
    it.payload_byte   = pbyte;
    return it;
  endfunction

  function automatic in_t random_item(input op_e op);
    return make_item(op, 8'($urandom), 8'($urandom), 10'($urandom), 8'($urandom));
  endfunction

  task automatic put_item(input in_t it);
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic write_source_id(input logic [7:0] v);
    wait_drained();
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic push_frame(input int unsigned len, input bit noisy);
    in_t it;
    it = random_item(OpStart);
    it.payload_length = 10'(len);
    put_item(it);
    for (int unsigned k = 0; k < len; k++) begin
      if (noisy && $urandom_range(99) < 5) begin
        put_item(random_item(OpStart));
      end
      put_item(random_item(OpPayload));
    end
  endtask

  task automatic random_traffic(input int unsigned target);
    in_t         it;
    int unsigned r;
    int unsigned len;
    while (items_sent < target) begin
      if ($urandom_range(99) < 12) begin
        it = random_item($urandom_range(1) ? OpPayload : OpStart);
        if (it.operation == OpStart) begin
          it.payload_length = 10'($urandom_range(1023, LenLimit + 1));
        end
        put_item(it);
      end
      r   = $urandom_range(99);
      len = (r < 15) ? 0 : (r < 85) ? $urandom_range(8, 1) : $urandom_range(40, 9);
      push_frame(len, 1'b1);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    put_item(make_item(OpPayload, 8'h00, 8'h00, 10'h000, 8'hFF));
    put_item(make_item(OpStart, 8'hFF, 8'h00, 10'd0, 8'h00));
    put_item(make_item(OpStart, 8'h12, 8'h34, 10'(LenLimit + 1), 8'hAA));
    put_item(make_item(OpStart, 8'h00, 8'hFF, 10'h3FF, 8'h55));
    put_item(make_item(OpStart, 8'h00, 8'hFF, 10'd3, 8'hFF));
    put_item(make_item(OpPayload, 8'hFF, 8'hFF, 10'h3FF, 8'h00));
    put_item(make_item(OpStart, 8'hAB, 8'hCD, 10'd0, 8'h00));
    put_item(make_item(OpStart, 8'h01, 8'h02, 10'h3FF, 8'h00));
    put_item(make_item(OpPayload, 8'h00, 8'h00, 10'h000, 8'hFF));
    put_item(make_item(OpPayload, 8'h3C, 8'hC3, 10'h155, 8'h5A));
    put_item(make_item(OpPayload, 8'h00, 8'h00, 10'h000, 8'h00));

    write_source_id(8'h00);
    put_item(make_item(OpStart, 8'h55, 8'hAA, 10'd1, 8'h00));
    put_item(make_item(OpPayload, 8'h00, 8'h00, 10'h000, 8'hA5));
    put_item(make_item(OpStart, 8'h00, 8'h00, 10'd0, 8'hFF));

    write_source_id(8'hFF);
    put_item(make_item(OpStart, 8'hFF, 8'hFF, 10'd2, 8'h00));
    put_item(make_item(OpPayload, 8'h00, 8'h00, 10'h000, 8'h00));
    put_item(make_item(OpPayload, 8'h00, 8'h00, 10'h000, 8'hFF));

    write_source_id(8'($urandom));
    random_traffic(90);

    in_gap_pct    = 0;
    out_gap_pct   = 0;
    hold_requests <= hold_requests + 1;
    random_traffic(170);
    in_gap_pct    = 6;
    out_gap_pct   = 6;

    write_source_id(8'($urandom));
    push_frame(40, 1'b0);
    random_traffic(240);

    wait_drained();
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS crc16_frame_encoder_top");
    end else begin
      $display("FAIL crc16_frame_encoder_top");
    end
    $finish;
  end

endmodule
